>>> src/sdag_pkg.sv
// ----------------------------------------------------------------------------
// sdag_pkg
// Shared types and constants for the scanline display address generator.
// ----------------------------------------------------------------------------
package sdag_pkg;

    localparam int LINE_W  = 16;
    localparam int ADDR_W  = 16;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // display_control bit positions
    localparam int CTL_ENABLE_BIT   = 15;
    localparam int CTL_NOINVERT_BIT = 10;

    localparam logic [ADDR_W-1:0] ADDR_INVERT_MASK = 16'hFFFC;

    typedef logic [LINE_W-1:0] t_line;
    typedef logic [ADDR_W-1:0] t_addr;

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_CONTROL = 3'd0,
        CFG_DISPLAY_START   = 3'd1,
        CFG_INTERRUPT_LINE  = 3'd2,
        CFG_TAP_OFFSET      = 3'd3,
        CFG_VBLANK_END      = 3'd4,
        CFG_VBLANK_START    = 3'd5,
        CFG_VERTICAL_TOTAL  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]      display_control;
        logic [15:0]      display_start;
        logic [15:0]      interrupt_line;
        logic [COL_W-1:0] tap_offset;
        logic [15:0]      vblank_end;
        logic [15:0]      vblank_start;
        logic [15:0]      vertical_total;
    } t_cfg;

    typedef struct packed {
        t_line            next_line;
        logic             display_irq;
        logic             active;
        logic [ROW_W-1:0] row_addr;
        logic [COL_W-1:0] col_addr;
    } t_res;

endpackage

>>> src/sdag_intf.sv
// ----------------------------------------------------------------------------
// sdag_intf
// Valid/ready channels: scanline requests, results and register writes.
// ----------------------------------------------------------------------------
interface sdag_line_if;
    import sdag_pkg::*;
    logic  valid;
    logic  ready;
    t_line line;

    modport source (output valid, output line, input ready);
    modport sink   (input valid, input line, output ready);
endinterface

interface sdag_res_if;
    import sdag_pkg::*;
    logic             valid;
    logic             ready;
    t_line            next_line;
    logic             display_irq;
    logic             active;
    logic [ROW_W-1:0] row_addr;
    logic [COL_W-1:0] col_addr;

    modport source (output valid, output next_line, output display_irq, output active,
                    output row_addr, output col_addr, input ready);
    modport sink   (input valid, input next_line, input display_irq, input active,
                    input row_addr, input col_addr, output ready);
endinterface

interface sdag_cfg_if;
    import sdag_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/sdag_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdag_cfg_regs
// Configuration register file; writes are registered and never stall.
// ----------------------------------------------------------------------------
module sdag_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdag_cfg_if.sink      i_cfg_if,
    output sdag_pkg::t_cfg o_cfg
);
    import sdag_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg_if.ready = 1'b1;
    assign o_cfg          = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_if.valid) begin
            case (t_cfg_idx'(i_cfg_if.index))
                CFG_DISPLAY_CONTROL: n_cfg.display_control = i_cfg_if.data;
                CFG_DISPLAY_START:   n_cfg.display_start   = i_cfg_if.data;
                CFG_INTERRUPT_LINE:  n_cfg.interrupt_line  = i_cfg_if.data;
                CFG_TAP_OFFSET:      n_cfg.tap_offset      = i_cfg_if.data[COL_W-1:0];
                CFG_VBLANK_END:      n_cfg.vblank_end      = i_cfg_if.data;
                CFG_VBLANK_START:    n_cfg.vblank_start    = i_cfg_if.data;
                CFG_VERTICAL_TOTAL:  n_cfg.vertical_total  = i_cfg_if.data;
                default:             n_cfg = r_cfg; // unmapped index: drop
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Unmapped writes leave every register untouched
    a_unmapped_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_if.valid && (i_cfg_if.index > CFG_VERTICAL_TOTAL) |=> $stable(r_cfg))
        else $error("write to unmapped index changed a register");

    a_tap_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_if.valid && (i_cfg_if.index == CFG_TAP_OFFSET)
        |=> r_cfg.tap_offset == $past(i_cfg_if.data[COL_W-1:0]))
        else $error("tap offset write lost");

    a_vtotal_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_if.valid && (i_cfg_if.index == CFG_VERTICAL_TOTAL)
        |=> r_cfg.vertical_total == $past(i_cfg_if.data))
        else $error("vertical total write lost");

endmodule

>>> src/sdag_core.sv
// ----------------------------------------------------------------------------
// sdag_core
// Per-line logic: interrupt match, address reload, address outputs and step, next-line count.
// ----------------------------------------------------------------------------
module sdag_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdag_pkg::t_cfg  i_cfg,
    input  sdag_pkg::t_line i_line,
    input  logic            i_fire,
    output sdag_pkg::t_res  o_res
);
    import sdag_pkg::*;

    t_addr r_addr;
    t_addr n_addr;

    always_comb begin
        logic              reload;
        logic              act;
        t_addr             cur;
        t_addr             eff;
        t_addr             stepped;
        logic [LINE_W:0]   sum;

        reload = (i_line == i_cfg.vblank_start);
        act    = (i_line >= i_cfg.vblank_end) && (i_line < i_cfg.vblank_start);
        cur    = reload ? i_cfg.display_start : r_addr;
        eff    = i_cfg.display_control[CTL_NOINVERT_BIT] ? cur : (cur ^ ADDR_INVERT_MASK);

        // Count down the low bits, then drop the high bits by the increment
        if (cur[1:0] == 2'b00) begin
            stepped = {cur[15:2] - {6'd0, i_cfg.display_control[9:2]},
                       i_cfg.display_start[1:0]};
        end else begin
            stepped = {cur[15:2], cur[1:0] - 2'd1};
        end

        n_addr = act ? stepped : cur;

        sum = {1'b0, i_line} + {{LINE_W{1'b0}}, 1'b1};
        o_res.next_line   = (sum >= {1'b0, i_cfg.vertical_total}) ? '0 : sum[LINE_W-1:0];
        o_res.display_irq = i_cfg.display_control[CTL_ENABLE_BIT] &&
                            (i_line == i_cfg.interrupt_line);
        o_res.active      = act;
        o_res.row_addr    = act ? eff[15:4] : '0;
        o_res.col_addr    = act ? ({3'd0, eff[6:2], 6'd0} | i_cfg.tap_offset) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_fire) begin
            r_addr <= n_addr;
        end
    end

    a_addr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_addr))
        else $error("display address moved without a line");

    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_line == i_cfg.vblank_start)
        |=> r_addr == $past(i_cfg.display_start))
        else $error("display address not reloaded at vblank start");

    a_low_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.active && (r_addr[1:0] != 2'b00)
        |=> r_addr == {$past(r_addr[15:2]), $past(r_addr[1:0]) - 2'd1})
        else $error("low address count did not step down");

endmodule

>>> src/scanline_display_address_generator.sv
// ----------------------------------------------------------------------------
// scanline_display_address_generator
// Per-scanline display address generator: interrupt match, address reload,
// row/column address output and address step, next-line count.
// ----------------------------------------------------------------------------
//
//  Channel     Dir   Payload                                   Handshake
//  ---------   ---   ---------------------------------------   -----------
//  i_line_if   in    line                                      valid/ready
//  o_res_if    out   next_line, display_irq, active,           valid/ready
//                    row_addr, col_addr
//  i_cfg_if    in    index (register), data                    valid/ready
//
//  One line request per cycle sustained while o_res_if.ready stays high. A
//  request is worked out by the core from the input register; the result
//  register then takes the result and presents it on o_res_if.
//  The display address register is updated as each request passes the core.
//  A stalled result holds the result register; the input register still
//  takes one further request, after which i_line_if.ready drops.
//  Reset (synchronous, active low) clears both valid flags, the registers
//  of the configuration port and the address.
//  Register writes are always taken; the configuration port never stalls.
//
module scanline_display_address_generator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdag_line_if.sink i_line_if,
    sdag_res_if.source o_res_if,
    sdag_cfg_if.sink  i_cfg_if
);
    import sdag_pkg::*;

    t_cfg  w_cfg;
    t_res  w_res;

    logic  r_in_valid;
    t_line r_line;
    logic  r_out_valid;
    t_res  r_out;

    logic  w_adv;   // input register moves into the result register
    logic  w_fire;  // a request is worked out this cycle

    sdag_cfg_regs u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_if (i_cfg_if),
        .o_cfg    (w_cfg)
    );

    sdag_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_line  (r_line),
        .i_fire  (w_fire),
        .o_res   (w_res)
    );

    // Result register free, or being emptied this cycle
    assign w_adv  = !r_out_valid || o_res_if.ready;
    assign w_fire = r_in_valid && w_adv;

    assign i_line_if.ready = !r_in_valid || w_adv;

    // Input register: valid flag under reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_line_if.ready) begin
            r_in_valid <= i_line_if.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line_if.ready && i_line_if.valid) begin
            r_line <= i_line_if.line;
        end
    end

    // Result register: load on advance, hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_res_if.valid       = r_out_valid;
    assign o_res_if.next_line   = r_out.next_line;
    assign o_res_if.display_irq = r_out.display_irq;
    assign o_res_if.active      = r_out.active;
    assign o_res_if.row_addr    = r_out.row_addr;
    assign o_res_if.col_addr    = r_out.col_addr;

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a request");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_line))
        else $error("held request lost or changed");

    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.active |-> (r_out.row_addr == '0) && (r_out.col_addr == '0))
        else $error("addresses driven on an inactive line");

endmodule
